// ===== src/nhlk_pkg.sv =====
package nhlk_pkg;

  localparam logic [31:0] SEED_VALUE = 32'h5A3C_6E2D;
  localparam logic [31:0] STEP_MUL   = 32'h0001_003F;
  localparam logic [31:0] STEP_XOR   = 32'hDEAD_BEEF;
  localparam logic [31:0] FINAL_MUL  = 32'h045D_9F3B;
  localparam logic [15:0] GROUP0_XOR = 16'hA5A5;
  localparam logic [15:0] GROUP1_XOR = 16'h5A5A;
  localparam logic [15:0] GROUP2_XOR = 16'h1234;
  localparam logic [15:0] GROUP3_XOR = 16'hFEDC;
  localparam logic [5:0]  LEN_MIN    = 6'd3;
  localparam logic [5:0]  LEN_MAX    = 6'd63;

  typedef struct packed {
    logic [7:0]  name_byte;
    logic        last_byte;
    logic [63:0] offered_key;
  } in_t;

  typedef struct packed {
    logic [63:0] expected_key;
    logic        key_matches;
    logic        length_bad;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ROT,
    S_FMUL,
    S_FIN
  } state_t;

  // four 16-bit groups from the finalised hash, group 0 on top
  function automatic logic [63:0] make_key(input logic [31:0] h);
    logic [31:0] r7;
    logic [31:0] r13;
    r7  = {h[24:0], h[31:25]};
    r13 = {h[18:0], h[31:19]};
    return {h[15:0] ^ GROUP0_XOR, h[31:16] ^ GROUP1_XOR,
            r7[15:0] ^ GROUP2_XOR, r13[15:0] ^ GROUP3_XOR};
  endfunction

endpackage

// ===== src/nhlk_mul.sv =====
// shared 32x32 multiplier, low word kept, result registered
module nhlk_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic [31:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= full;
    end
  end

endmodule

// ===== src/name_hash_license_key_check.sv =====
// Name-hash key check. Takes one name byte per item; zero bytes are skipped.
// A non-last byte passes through accept, multiply and rotate/xor; a last byte
// adds the finaliser multiply and key build; a zero byte marked last goes
// from accept straight to the finaliser multiply, one not marked last is only
// accepted. Both multiplies use the one registered 32x32 multiplier, and the
// input stalls until the item is done. One result per name, on the last byte;
// the next name can start while that result waits in the output register.
module name_hash_license_key_check #(
  parameter int NAME_LIMIT = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  nhlk_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output nhlk_pkg::out_t out_data
);

  nhlk_pkg::state_t state, state_next;

  logic [31:0] running_hash, running_hash_next;
  logic [5:0]  name_length, name_length_next;
  logic [31:0] op_a, op_a_next;
  logic [31:0] op_b, op_b_next;
  logic [3:0]  nib;
  logic        last;
  logic [63:0] offered;
  logic        out_valid_next;
  nhlk_pkg::out_t out_data_next;

  logic        accept;
  logic        out_free;
  logic        mul_en;
  logic [31:0] prod;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [31:0] step_hash;
  logic [31:0] fin_hash;
  logic [63:0] key;
  logic        bad;

  nhlk_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (op_a),
    .b   (op_b),
    .p   (prod)
  );

  assign in_stall = (state != nhlk_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign mul_en   = (state == nhlk_pkg::S_MUL) || (state == nhlk_pkg::S_FMUL);

  // byte is sign-extended as a signed char
  assign sum       = running_hash + {{24{in_data.name_byte[7]}}, in_data.name_byte};
  assign dbl       = {prod, prod} << nib;
  assign step_hash = dbl[63:32] ^ nhlk_pkg::STEP_XOR;
  assign fin_hash  = prod ^ {16'h0000, prod[31:16]};
  assign key       = nhlk_pkg::make_key(fin_hash);
  assign bad       = (name_length < nhlk_pkg::LEN_MIN) || (name_length >= 6'(NAME_LIMIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nhlk_pkg::S_IDLE;
      running_hash <= nhlk_pkg::SEED_VALUE;
      name_length  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      running_hash <= running_hash_next;
      name_length  <= name_length_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_a     <= op_a_next;
    op_b     <= op_b_next;
    out_data <= out_data_next;
    if (accept) begin
      nib     <= in_data.name_byte[3:0];
      last    <= in_data.last_byte;
      offered <= in_data.offered_key;
    end
  end

  always_comb begin
    state_next        = state;
    running_hash_next = running_hash;
    name_length_next  = name_length;
    op_a_next         = op_a;
    op_b_next         = op_b;
    out_valid_next    = out_valid && out_stall;
    out_data_next     = out_data;
    unique case (state)
      nhlk_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data.name_byte != 8'h00) begin
            op_a_next  = sum;
            op_b_next  = nhlk_pkg::STEP_MUL;
            state_next = nhlk_pkg::S_MUL;
            if (name_length != nhlk_pkg::LEN_MAX) begin
              name_length_next = name_length + 6'd1;
            end
          end else if (in_data.last_byte) begin
            op_a_next  = running_hash ^ {16'h0000, running_hash[31:16]};
            op_b_next  = nhlk_pkg::FINAL_MUL;
            state_next = nhlk_pkg::S_FMUL;
          end
        end
      end
      nhlk_pkg::S_MUL: begin
        state_next = nhlk_pkg::S_ROT;
      end
      nhlk_pkg::S_ROT: begin
        running_hash_next = step_hash;
        if (last) begin
          op_a_next  = step_hash ^ {16'h0000, step_hash[31:16]};
          op_b_next  = nhlk_pkg::FINAL_MUL;
          state_next = nhlk_pkg::S_FMUL;
        end else begin
          state_next = nhlk_pkg::S_IDLE;
        end
      end
      nhlk_pkg::S_FMUL: begin
        state_next = nhlk_pkg::S_FIN;
      end
      nhlk_pkg::S_FIN: begin
        // wait here while the previous result is still held
        if (out_free) begin
          out_valid_next             = 1'b1;
          out_data_next.expected_key = key;
          out_data_next.length_bad   = bad;
          out_data_next.key_matches  = !bad && (offered == key);
          running_hash_next          = nhlk_pkg::SEED_VALUE;
          name_length_next           = '0;
          state_next                 = nhlk_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = nhlk_pkg::S_IDLE;
      end
    endcase
  end

  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && (state != nhlk_pkg::S_FIN) |=> !out_valid)
    else $error("result held after it was taken");

  a_bad_no_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.key_matches && out_data.length_bad))
    else $error("match flagged on a bad length");

  a_name_restart: assert property (@(posedge clk) disable iff (rst)
    (state == nhlk_pkg::S_FIN) && out_free |=>
      (name_length == 6'd0) && (running_hash == nhlk_pkg::SEED_VALUE) && out_valid)
    else $error("state not cleared after a name");

  a_byte_to_mul: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.name_byte != 8'h00) |=> (state == nhlk_pkg::S_MUL))
    else $error("non-zero byte skipped the multiply");

endmodule

// ===== sim/tb_name_hash_license_key_check.sv =====
module tb_name_hash_license_key_check;

  localparam int NAME_LIMIT   = 32;
  localparam int RANDOM_CHARS = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TIMEOUT      = 1000000;

  typedef logic [7:0] char_q_t[$];

  typedef enum int {
    KEY_RANDOM,
    KEY_RIGHT,
    KEY_ONE_BIT_OFF,
    KEY_ZEROS,
    KEY_ONES
  } key_pick_t;

  logic           clk;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  nhlk_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  nhlk_pkg::out_t out_data;

  // pacing controls shared between the stimulus and the stall process
  bit tx_gaps;
  bit rx_random;
  bit hold_req;
  int chars_sent;
  int names_sent;

  name_hash_license_key_check #(.NAME_LIMIT(NAME_LIMIT)) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // one name character folded into the running hash
  function automatic logic [31:0] fold_char(logic [31:0] h, logic [7:0] c);
    logic [31:0] p;
    logic [3:0]  r;
    p = (h + {{24{c[7]}}, c}) * nhlk_pkg::STEP_MUL;
    r = c[3:0];
    if (r != 4'd0) begin
      p = (p << r) | (p >> (32 - r));
    end
    return p ^ nhlk_pkg::STEP_XOR;
  endfunction

  function automatic logic [31:0] avalanche(logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> 16);
    x = x * nhlk_pkg::FINAL_MUL;
    return x ^ (x >> 16);
  endfunction

  // rotations taken as windows of the doubled word
  function automatic logic [63:0] key_from(logic [31:0] h);
    logic [63:0] hh;
    hh = {h, h};
    return {h[15:0] ^ 16'hA5A5, h[31:16] ^ 16'h5A5A,
            hh[40:25] ^ 16'h1234, hh[34:19] ^ 16'hFEDC};
  endfunction

  class key_check_board;
    logic [31:0]    hash;
    logic [5:0]     count;
    nhlk_pkg::out_t pending_keys[$];
    int             mismatches;
    int             verdicts;
    int             accepted;
    int             flagged;

    function new();
      hash  = nhlk_pkg::SEED_VALUE;
      count = '0;
    endfunction

    function void note_char(nhlk_pkg::in_t d);
      nhlk_pkg::out_t e;
      if (d.name_byte != 8'd0) begin
        hash = fold_char(hash, d.name_byte);
        if (count != nhlk_pkg::LEN_MAX) count++;
      end
      if (d.last_byte) begin
        e.expected_key = key_from(avalanche(hash));
        e.length_bad   = (count < nhlk_pkg::LEN_MIN) || (count >= NAME_LIMIT);
        e.key_matches  = !e.length_bad && (d.offered_key == e.expected_key);
        pending_keys.push_back(e);
        hash  = nhlk_pkg::SEED_VALUE;
        count = '0;
      end
    endfunction

    function void check_verdict(nhlk_pkg::out_t got);
      nhlk_pkg::out_t want;
      if (pending_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: key %h match %b len_bad %b",
                   got.expected_key, got.key_matches, got.length_bad);
        return;
      end
      want = pending_keys.pop_front();
      verdicts++;
      if (want.key_matches) accepted++;
      if (want.length_bad) flagged++;
      if (got.expected_key !== want.expected_key || got.key_matches !== want.key_matches ||
          got.length_bad !== want.length_bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: key exp %h got %h, match exp %b got %b, len_bad exp %b got %b",
                   want.expected_key, got.expected_key, want.key_matches,
                   got.key_matches, want.length_bad, got.length_bad);
      end
    endfunction

    function int pending();
      return pending_keys.size();
    endfunction
  endclass

  key_check_board sb;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("timeout with %0d results outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_verdict(out_data);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stall: runs of one level, or a long hold when asked
  initial begin
    int  run;
    bit  level;
    run       = 0;
    level     = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        level    = 1'b1;
        run      = HOLD_CYCLES;
      end else if (run == 0) begin
        level = rx_random && ($urandom_range(0, 2) == 0);
        run   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      run--;
      out_stall <= level;
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input nhlk_pkg::in_t d);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    sb.note_char(d);
    if (d.name_byte != 8'd0) chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_name(input char_q_t chars, input key_pick_t pick);
    logic [31:0]   h;
    logic [63:0]   k;
    nhlk_pkg::in_t d;
    h = nhlk_pkg::SEED_VALUE;
    foreach (chars[i]) if (chars[i] != 8'd0) h = fold_char(h, chars[i]);
    case (pick)
      KEY_RIGHT:       k = key_from(avalanche(h));
      KEY_ONE_BIT_OFF: k = key_from(avalanche(h)) ^ (64'd1 << $urandom_range(0, 63));
      KEY_ZEROS:       k = '0;
      KEY_ONES:        k = '1;
      default:         k = {$urandom, $urandom};
    endcase
    foreach (chars[i]) begin
      d.name_byte   = chars[i];
      d.last_byte   = (i == chars.size() - 1);
      d.offered_key = d.last_byte ? k : {$urandom, $urandom};
      send_item(d);
    end
    names_sent++;
  endtask

  // mostly valid lengths; a few short, boundary and saturating names
  function automatic char_q_t random_name();
    char_q_t q;
    int      len;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 6) len = $urandom_range(0, 2);
    else if (r < 11) len = $urandom_range(31, 33);
    else if (r < 13) len = $urandom_range(60, 70);
    else len = $urandom_range(3, 30);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 3) q.push_back(8'd0);
      q.push_back(8'($urandom_range(1, 255)));
    end
    // zero byte closing the name
    if (len == 0 || $urandom_range(0, 99) < 4) q.push_back(8'd0);
    return q;
  endfunction

  initial begin
    key_pick_t pick;
    int        r;
    bit        held;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    tx_gaps    = 1'b1;
    rx_random  = 1'b1;
    hold_req   = 1'b0;
    held       = 1'b0;
    chars_sent = 0;
    names_sent = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_name('{8'h41, 8'h62, 8'h63}, KEY_RIGHT);
    send_name('{8'h41}, KEY_RIGHT);
    send_name('{8'hFF, 8'h80}, KEY_RIGHT);
    send_name('{8'h00}, KEY_RANDOM);
    send_name('{8'h7F, 8'h00, 8'h01, 8'h10, 8'h00}, KEY_RIGHT);
    send_name('{8'hF0, 8'h0F, 8'hAA}, KEY_RANDOM);
    send_name('{8'h55, 8'hAA, 8'h01}, KEY_ONE_BIT_OFF);
    send_name('{8'h01, 8'h02, 8'h03}, KEY_ZEROS);
    send_name('{8'hFF, 8'hFF, 8'hFF}, KEY_ONES);

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      tx_gaps   = (chars_sent < 600) || (chars_sent >= 1200);
      rx_random = (chars_sent < 600) || (chars_sent >= 1400);
      // long receiver hold while the sender keeps pushing items
      if (chars_sent >= 900 && !held) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 45) pick = KEY_RIGHT;
      else if (r < 60) pick = KEY_ONE_BIT_OFF;
      else pick = KEY_RANDOM;
      send_name(random_name(), pick);
    end
    in_valid <= 1'b0;

    for (int n = 0; n < 50000 && sb.pending() > 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.pending() > 0) $display("%0d expected results never arrived", sb.pending());
    $display("%0d names sent, %0d verdicts checked: %0d keys accepted, %0d length flags",
             names_sent, sb.verdicts, sb.accepted, sb.flagged);
    $display("mixed empty, short, saturating and zero-byte names; %0d-cycle output hold",
             HOLD_CYCLES);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/nhlk_pkg.sv
src/nhlk_mul.sv
src/name_hash_license_key_check.sv
sim/tb_name_hash_license_key_check.sv
